>>> src/dertlv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dertlv_pkg
// Shared opcodes, sizes and the element type of the DER TLV encoder.
// ----------------------------------------------------------------------------
package dertlv_pkg;

	localparam int unsigned MaxOctets = 7;
	localparam int unsigned CntW      = 3;

	localparam logic [2:0] OP_HEADER  = 3'd0;
	localparam logic [2:0] OP_INTEGER = 3'd1;
	localparam logic [2:0] OP_BITSTR  = 3'd2;
	localparam logic [2:0] OP_BOOLEAN = 3'd3;
	localparam logic [2:0] OP_NULL    = 3'd4;

	localparam logic [7:0] LEN_SHORT_MAX = 8'h7f;
	localparam logic [7:0] LEN_LONG      = 8'h80;
	localparam logic [7:0] BOOL_TRUE     = 8'hff;

	typedef logic [7:0] octet_t;

	// one complete element, octet 0 goes out first
	typedef struct packed {
		octet_t [MaxOctets-1:0] octets;
		logic   [CntW-1:0]      count;
		logic                   error;
	} elem_t;

endpackage
`default_nettype wire

>>> src/dertlv_build.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dertlv_build
// Combinational encoder: turns one registered request into the octets of
// one DER element, their count and an error flag.
// ----------------------------------------------------------------------------
module dertlv_build (
	input  wire logic [2:0]         opcode,
	input  wire logic [7:0]         tag_octet,
	input  wire logic [31:0]        value,
	input  wire logic [31:0]        content_length,
	output      dertlv_pkg::elem_t  elem
);

	logic [2:0] len_n;
	logic [2:0] int_n;
	logic [2:0] bs_n;
	logic [7:0] top_byte;
	logic [2:0] top_pos;
	logic [7:0] unused;

	// length octets needed for the long form
	always_comb begin
		if (content_length[31:24] != 8'd0) begin
			len_n = 3'd4;
		end else if (content_length[23:16] != 8'd0) begin
			len_n = 3'd3;
		end else if (content_length[15:8] != 8'd0) begin
			len_n = 3'd2;
		end else begin
			len_n = 3'd1;
		end
	end

	// minimal two's complement: drop octets that only repeat the sign
	always_comb begin
		if (value[31:7] == '0 || value[31:7] == '1) begin
			int_n = 3'd1;
		end else if (value[31:15] == '0 || value[31:15] == '1) begin
			int_n = 3'd2;
		end else if (value[31:23] == '0 || value[31:23] == '1) begin
			int_n = 3'd3;
		end else begin
			int_n = 3'd4;
		end
	end

	// bit string: content octets and the highest set bit of the top one
	always_comb begin
		if (value[31:24] != 8'd0) begin
			bs_n     = 3'd4;
			top_byte = value[31:24];
		end else if (value[23:16] != 8'd0) begin
			bs_n     = 3'd3;
			top_byte = value[23:16];
		end else if (value[15:8] != 8'd0) begin
			bs_n     = 3'd2;
			top_byte = value[15:8];
		end else if (value[7:0] != 8'd0) begin
			bs_n     = 3'd1;
			top_byte = value[7:0];
		end else begin
			bs_n     = 3'd0;
			top_byte = 8'd0;
		end
	end

	always_comb begin
		top_pos = 3'd7;
		for (int i = 0; i < 8; i++) begin
			if (top_byte[i]) begin
				top_pos = 3'(i);
			end
		end
	end

	assign unused = (bs_n == 3'd0) ? 8'd0 : {5'd0, 3'd7 - top_pos};

	always_comb begin
		elem.octets = '0;
		elem.count  = '0;
		elem.error  = 1'b0;
		elem.octets[0] = tag_octet;
		case (opcode)
			dertlv_pkg::OP_HEADER: begin
				if (content_length <= {24'd0, dertlv_pkg::LEN_SHORT_MAX}) begin
					elem.octets[1] = content_length[7:0];
					elem.count     = 3'd2;
				end else begin
					elem.octets[1] = dertlv_pkg::LEN_LONG | {5'd0, len_n};
					for (int k = 0; k < 4; k++) begin
						if (3'(k) < len_n) begin
							elem.octets[2+k] = 8'(content_length >> (8 * (len_n - 3'(k) - 3'd1)));
						end
					end
					elem.count = len_n + 3'd2;
				end
			end
			dertlv_pkg::OP_INTEGER: begin
				elem.octets[1] = {5'd0, int_n};
				for (int k = 0; k < 4; k++) begin
					if (3'(k) < int_n) begin
						elem.octets[2+k] = 8'(value >> (8 * (int_n - 3'(k) - 3'd1)));
					end
				end
				elem.count = int_n + 3'd2;
			end
			dertlv_pkg::OP_BITSTR: begin
				if (value[31]) begin
					elem.octets[0] = 8'd0;
					elem.count     = 3'd1;
					elem.error     = 1'b1;
				end else begin
					elem.octets[1] = {5'd0, bs_n} + 8'd1;
					elem.octets[2] = unused;
					// octet k carries source bits 8k..8k+7, reversed
					for (int k = 0; k < 4; k++) begin
						if (3'(k) < bs_n) begin
							for (int b = 0; b < 8; b++) begin
								elem.octets[3+k][7-b] = value[8*k+b];
							end
						end
					end
					elem.count = bs_n + 3'd3;
				end
			end
			dertlv_pkg::OP_BOOLEAN: begin
				elem.octets[1] = 8'd1;
				elem.octets[2] = (value != 32'd0) ? dertlv_pkg::BOOL_TRUE : 8'd0;
				elem.count     = 3'd3;
			end
			dertlv_pkg::OP_NULL: begin
				elem.octets[1] = 8'd0;
				elem.count     = 3'd2;
			end
			default: begin
				// unused opcode: nothing goes out
				elem.count = 3'd0;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> src/der_primitive_tlv_encoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// der_primitive_tlv_encoder_core
// Encodes one primitive ASN.1 DER element per request, one octet per beat.
// ----------------------------------------------------------------------------
// path: with nothing draining, an accepted request passes from the input
// register into the output shift register; a request taken while an element
// drains waits in the input register until the last octet of that element
// goes out. flow: elements are 1 to 7 octets long, none for an unused opcode,
// and drain one octet per beat from the output shift register; a waiting
// request is loaded while the last octet of the previous one goes out.
// reset: clears the request and output valid state; no results pending.
module der_primitive_tlv_encoder_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output      logic        busy,
	input  wire logic [2:0]  opcode,
	input  wire logic [7:0]  tag_octet,
	input  wire logic [31:0] value,
	input  wire logic [31:0] content_length,
	output      logic        out_valid,
	output      logic [7:0]  out_byte,
	output      logic        last,
	output      logic        error
);

	logic        req_vld_s1;
	logic [2:0]  opcode_s1;
	logic [7:0]  tag_s1;
	logic [31:0] value_s1;
	logic [31:0] clen_s1;

	dertlv_pkg::elem_t                              elem;
	dertlv_pkg::octet_t [dertlv_pkg::MaxOctets-1:0] octets_q;
	logic [dertlv_pkg::CntW-1:0]                    cnt_q;
	logic                                           err_q;

	logic accept;
	logic load;

	assign load   = req_vld_s1 && (cnt_q <= 3'd1);
	assign busy   = req_vld_s1 && (cnt_q > 3'd1);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_vld_s1 <= 1'b0;
		end else if (accept) begin
			req_vld_s1 <= 1'b1;
		end else if (load) begin
			req_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1 <= opcode;
			tag_s1    <= tag_octet;
			value_s1  <= value;
			clen_s1   <= content_length;
		end
	end

	dertlv_build u_build (
		.opcode         (opcode_s1),
		.tag_octet      (tag_s1),
		.value          (value_s1),
		.content_length (clen_s1),
		.elem           (elem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= elem.count;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	// output shift register, octet 0 is the current beat
	always_ff @(posedge clk) begin
		if (load) begin
			octets_q <= elem.octets;
			err_q    <= elem.error;
		end else begin
			for (int k = 0; k < dertlv_pkg::MaxOctets - 1; k++) begin
				octets_q[k] <= octets_q[k+1];
			end
		end
	end

	assign out_valid = (cnt_q != '0);
	assign out_byte  = octets_q[0];
	assign last      = (cnt_q == 3'd1);
	assign error     = out_valid && err_q;

endmodule
`default_nettype wire

>>> src/dertlv_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dertlv_chk
// Port-level checks of the DER TLV encoder, bound to the top level.
// ----------------------------------------------------------------------------
module dertlv_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       busy,
	input wire logic       out_valid,
	input wire logic [7:0] out_byte,
	input wire logic       last,
	input wire logic       error
);

	// an error beat is a lone zero octet that closes the element
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		error |-> (out_valid && last && out_byte == 8'd0))
		else $error("error beat is not a single zero last octet");

	a_flags_need_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> (!last && !error))
		else $error("last or error without a beat");

	// the next request is always taken while the last octet goes out
	a_last_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> !busy)
		else $error("busy on the last octet of an element");

	a_busy_streaming: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (out_valid && !last))
		else $error("busy while no element is draining");

endmodule

bind der_primitive_tlv_encoder_core dertlv_chk u_dertlv_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.busy      (busy),
	.out_valid (out_valid),
	.out_byte  (out_byte),
	.last      (last),
	.error     (error)
);
`default_nettype wire

>>> tb/sv/der_tlv_octet_checker.sv
// ----------------------------------------------------------------------------
// der_tlv_octet_checker
// Watches the request and octet channels of the DER TLV encoder. It works out
// the octets that each accepted request must produce and compares every
// octet beat, field by field, against the oldest one still outstanding.
// ----------------------------------------------------------------------------
module der_tlv_octet_checker
	import dertlv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  opcode,
	input  logic [7:0]  tag_octet,
	input  logic [31:0] value,
	input  logic [31:0] content_length,
	input  logic        out_valid,
	input  logic [7:0]  out_byte,
	input  logic        last,
	input  logic        error,
	output int          fail_count,
	output int          pending
);

	localparam int ReportMax = 10;

	typedef struct packed {
		octet_t data;
		logic   last;
		logic   err;
	} octet_beat_t;

	octet_beat_t expected_octets[$];

	// appends the octets of one element to the expected stream
	function automatic void encode_element(input logic [2:0] op, input octet_t tag,
			input logic [31:0] val, input logic [31:0] clen);
		octet_t      octs[$];
		octet_beat_t beat;
		int          nlen;
		int          nval;
		int          nbits;
		int          nbytes;
		logic [31:0] rev;
		logic [7:0]  top;
		logic        nextbit;

		if (op > OP_NULL)
			return;
		if (op == OP_BITSTR && val[31]) begin
			beat = '{data: 8'h00, last: 1'b1, err: 1'b1};
			expected_octets.push_back(beat);
			return;
		end
		octs.push_back(tag);
		case (op)
			OP_HEADER: begin
				if (clen <= 32'(LEN_SHORT_MAX)) begin
					octs.push_back(clen[7:0]);
				end else begin
					if (clen <= 32'h0000_00ff)
						nlen = 1;
					else if (clen <= 32'h0000_ffff)
						nlen = 2;
					else if (clen <= 32'h00ff_ffff)
						nlen = 3;
					else
						nlen = 4;
					octs.push_back(LEN_LONG | 8'(nlen));
					for (int k = nlen - 1; k >= 0; k--)
						octs.push_back(8'(clen >> (8 * k)));
				end
			end
			OP_INTEGER: begin
				nval = 4;
				// strip leading octets that only repeat the sign
				while (nval > 1) begin
					top     = 8'(val >> (8 * (nval - 1)));
					nextbit = val[8 * (nval - 1) - 1];
					if ((top == 8'h00 && !nextbit) || (top == 8'hff && nextbit))
						nval--;
					else
						break;
				end
				octs.push_back(8'(nval));
				for (int k = nval - 1; k >= 0; k--)
					octs.push_back(8'(val >> (8 * k)));
			end
			OP_BITSTR: begin
				nbits = 0;
				for (int i = 0; i < 32; i++) begin
					rev[31 - i] = val[i];
					if (val[i])
						nbits = i + 1;
				end
				nbytes = (nbits + 7) / 8;
				octs.push_back(8'(1 + nbytes));
				octs.push_back(8'((8 - (nbits % 8)) % 8));
				for (int i = 0; i < nbytes; i++)
					octs.push_back(8'(rev >> (24 - 8 * i)));
			end
			OP_BOOLEAN: begin
				octs.push_back(8'h01);
				octs.push_back((val != 32'd0) ? BOOL_TRUE : 8'h00);
			end
			default: begin
				octs.push_back(8'h00);
			end
		endcase
		foreach (octs[k]) begin
			beat = '{data: octs[k], last: (k == octs.size() - 1), err: 1'b0};
			expected_octets.push_back(beat);
		end
	endfunction

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	always @(posedge clk) begin
		octet_beat_t want;

		if (arst_n) begin
			// octets of a request come out only after it has passed the input register, so pop first
			if (out_valid === 1'b1) begin
				if (expected_octets.size() == 0) begin
					if (fail_count < ReportMax)
						$display("%0t: unexpected octet beat %02h last=%b error=%b",
							$realtime, out_byte, last, error);
					fail_count++;
				end else begin
					want = expected_octets.pop_front();
					if (out_byte !== want.data || last !== want.last || error !== want.err) begin
						if (fail_count < ReportMax)
							$display("%0t: octet mismatch: expected %02h last=%b error=%b, got %02h last=%b error=%b",
								$realtime, want.data, want.last, want.err, out_byte, last, error);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				encode_element(opcode, tag_octet, value, content_length);
			pending = expected_octets.size();
		end
	end

endmodule

>>> tb/sv/tb_der_primitive_tlv_encoder_core.sv
// ----------------------------------------------------------------------------
// tb_der_primitive_tlv_encoder_core
// Drives directed and random DER encode requests into the encoder with random
// gaps and a drained pause, while a checker beside the block predicts and
// compares every octet beat.
// ----------------------------------------------------------------------------
module tb_der_primitive_tlv_encoder_core;
	import dertlv_pkg::*;

	localparam int NumRandom  = 480;
	localparam int CycleLimit = 200000;
	localparam int IdlePct    = 28;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        start          = 1'b0;
	logic [2:0]  opcode         = OP_HEADER;
	logic [7:0]  tag_octet      = 8'h00;
	logic [31:0] value          = 32'd0;
	logic [31:0] content_length = 32'd0;
	logic        busy;
	logic        out_valid;
	logic [7:0]  out_byte;
	logic        last;
	logic        error;

	int fail_count;
	int pending;
	int cycle_count;
	bit idle_on;

	always #5 clk = ~clk;

	der_primitive_tlv_encoder_core u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.opcode         (opcode),
		.tag_octet      (tag_octet),
		.value          (value),
		.content_length (content_length),
		.out_valid      (out_valid),
		.out_byte       (out_byte),
		.last           (last),
		.error          (error)
	);

	der_tlv_octet_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.opcode         (opcode),
		.tag_octet      (tag_octet),
		.value          (value),
		.content_length (content_length),
		.out_valid      (out_valid),
		.out_byte       (out_byte),
		.last           (last),
		.error          (error),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	// start stays high across back-to-back beats, it only drops in a gap
	task automatic send_request(input logic [2:0] op, input octet_t tag,
			input logic [31:0] val, input logic [31:0] clen);
		bit taken;

		while (idle_on && $urandom_range(0, 99) < IdlePct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start          <= 1'b1;
		opcode         <= op;
		tag_octet      <= tag;
		value          <= val;
		content_length <= clen;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		int          w;
		logic [31:0] r;

		r = $urandom;
		case ($urandom_range(0, 3))
			0: return r;
			1: return 32'($signed($urandom_range(0, 600)) - 300);
			2: begin
				w = $urandom_range(1, 32);
				return 32'($signed(r << (32 - w)) >>> (32 - w));
			end
			default: begin
				case ($urandom_range(0, 5))
					0: return 32'h7fff_ffff;
					1: return 32'h8000_0000;
					2: return 32'hffff_ffff;
					3: return 32'h0000_0000;
					4: return 32'h0000_0080;
					default: return 32'hffff_ff7f;
				endcase
			end
		endcase
	endfunction

	function automatic logic [31:0] pick_length();
		int w;

		w = $urandom_range(0, 32);
		if (w == 0)
			return 32'd0;
		return $urandom >> (32 - w);
	endfunction

	initial begin
		cycle_count = 0;
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		int          done;
		bit          paused;
		logic [2:0]  op;
		logic [31:0] val;

		idle_on = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// length forms: short, and long with one to four octets
		send_request(OP_HEADER, 8'h30, 32'd0, 32'h0000_0000);
		send_request(OP_HEADER, 8'hff, 32'd0, 32'h0000_007f);
		send_request(OP_HEADER, 8'h04, 32'd0, 32'h0000_0080);
		send_request(OP_HEADER, 8'h31, 32'd0, 32'h0000_0100);
		send_request(OP_HEADER, 8'h30, 32'd0, 32'h0001_0000);
		send_request(OP_HEADER, 8'h30, 32'd0, 32'h00ff_ffff);
		send_request(OP_HEADER, 8'h30, 32'd0, 32'hffff_ffff);
		// integer sign boundaries
		send_request(OP_INTEGER, 8'h02, 32'h0000_0000, 32'd0);
		send_request(OP_INTEGER, 8'h02, 32'hffff_ffff, 32'd0);
		send_request(OP_INTEGER, 8'h02, 32'h0000_0080, 32'd0);
		send_request(OP_INTEGER, 8'h02, 32'hffff_ff80, 32'd0);
		send_request(OP_INTEGER, 8'h02, 32'hffff_ff7f, 32'd0);
		send_request(OP_INTEGER, 8'h02, 32'h7fff_ffff, 32'hffff_ffff);
		send_request(OP_INTEGER, 8'h02, 32'h8000_0000, 32'd0);
		// bit strings: empty, one bit, full width, negative
		send_request(OP_BITSTR, 8'h03, 32'h0000_0000, 32'd0);
		send_request(OP_BITSTR, 8'h03, 32'h0000_0001, 32'd0);
		send_request(OP_BITSTR, 8'h03, 32'h0000_0100, 32'd0);
		send_request(OP_BITSTR, 8'h03, 32'h7fff_ffff, 32'd0);
		send_request(OP_BITSTR, 8'h03, 32'h8000_0000, 32'd0);
		send_request(OP_BITSTR, 8'h03, 32'hffff_ffff, 32'hffff_ffff);
		send_request(OP_BOOLEAN, 8'h01, 32'h0000_0000, 32'd0);
		send_request(OP_BOOLEAN, 8'h01, 32'h8000_0000, 32'd0);
		send_request(OP_NULL, 8'h05, 32'hffff_ffff, 32'hffff_ffff);
		// unused opcodes give no octets
		send_request(3'd5, 8'haa, 32'h1234_5678, 32'd0);
		send_request(3'd7, 8'h55, 32'hffff_ffff, 32'hffff_ffff);

		done   = 0;
		paused = 1'b0;
		while (done < NumRandom) begin
			idle_on = !(done >= 200 && done < 300);
			if (!paused && done == 120) begin
				wait_drained();
				paused = 1'b1;
			end
			if ($urandom_range(0, 99) < 5)
				op = 3'($urandom_range(5, 7));
			else
				op = 3'($urandom_range(0, 4));
			val = pick_value();
			if (op == OP_BITSTR && $urandom_range(0, 9) != 0)
				val[31] = 1'b0;
			send_request(op, 8'($urandom), val, pick_length());
			if (op <= OP_NULL)
				done++;
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> files.f
src/dertlv_pkg.sv
src/dertlv_build.sv
src/der_primitive_tlv_encoder_core.sv
src/dertlv_chk.sv
tb/sv/der_tlv_octet_checker.sv
tb/sv/tb_der_primitive_tlv_encoder_core.sv
